[sv/drd_pkg.sv]
// ----------------------------------------------------------------------------
// drd_pkg
// Types, register codes and helpers shared by the detection row decoder.
// ----------------------------------------------------------------------------
package drd_pkg;

	localparam int MAX_CLASSES = 128;
	localparam int CLASS_CAP = (MAX_CLASSES < 128) ? MAX_CLASSES : 128;

	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W = 59;

	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONF_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;

	typedef struct packed {
		logic [6:0] cls;
		logic [30:0] conf;
		logic signed [33:0] lx;
		logic signed [33:0] ty;
		logic signed [31:0] w;
		logic signed [31:0] h;
	} cand_t;

	// truncate toward zero after dropping sh fraction bits, saturate to 16 bits
	function automatic logic signed [15:0] trunc_sat16(input logic signed [PROD_W-1:0] val,
			input int unsigned sh);
		logic neg;
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] q;
		logic signed [15:0] res;
		neg = val[PROD_W-1];
		mag = neg ? PROD_W'(-val) : PROD_W'(val);
		q = mag >> sh;
		if (neg) begin
			res = (q > PROD_W'(32768)) ? -16'sd32768 : 16'(-q[15:0]);
		end else begin
			res = (q > PROD_W'(32767)) ? 16'sd32767 : $signed(q[15:0]);
		end
		return res;
	endfunction

endpackage

[sv/drd_box_scale.sv]
// ----------------------------------------------------------------------------
// drd_box_scale
// Scales a candidate box by the Q8.16 factors, truncates and saturates.
// ----------------------------------------------------------------------------
module drd_box_scale import drd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cand_valid,
	input  cand_t cand,
	output logic cand_free,
	input  logic [23:0] scale_x,
	input  logic [23:0] scale_y,
	output logic out_valid,
	input  logic out_stall,
	output logic [6:0] class_index,
	output logic [30:0] confidence,
	output logic signed [15:0] box_left,
	output logic signed [15:0] box_top,
	output logic signed [15:0] box_width,
	output logic signed [15:0] box_height
);

	logic valid_s2;
	logic [6:0] cls_s2;
	logic [30:0] conf_s2;
	logic signed [PROD_W-1:0] px_s2, py_s2, pw_s2, ph_s2;
	logic out_valid_q;
	logic out_free, s2_free;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_free = !valid_s2 || out_free;
	assign cand_free = s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && cand_valid) begin
			cls_s2 <= cand.cls;
			conf_s2 <= cand.conf;
			px_s2 <= PROD_W'(cand.lx) * PROD_W'($signed({1'b0, scale_x}));
			py_s2 <= PROD_W'(cand.ty) * PROD_W'($signed({1'b0, scale_y}));
			pw_s2 <= PROD_W'(cand.w) * PROD_W'($signed({1'b0, scale_x}));
			ph_s2 <= PROD_W'(cand.h) * PROD_W'($signed({1'b0, scale_y}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			class_index <= cls_s2;
			confidence <= conf_s2;
			box_left <= trunc_sat16(px_s2, 33);
			box_top <= trunc_sat16(py_s2, 33);
			box_width <= trunc_sat16(pw_s2, 32);
			box_height <= trunc_sat16(ph_s2, 32);
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/detection_row_decoder.sv]
// ----------------------------------------------------------------------------
// detection_row_decoder
// Streams detector output rows, tracks the best class score and emits one
// scaled corner-box candidate per row that passes both thresholds.
// ----------------------------------------------------------------------------
//   channel   signals                                   dir
//   input     in_valid in_stall element_value frame_start   in
//   output    out_valid out_stall class_index confidence box_*  out
//   config    cfg_write cfg_index cfg_data                  in
//
// one element per cycle unless stalled; row: class_count (1..128) + 5 elements
// a candidate passes three registers after its row's last element
// (candidate register, multiplier register, saturation register)
// in_stall rises only when all three result stages are full and out_stall holds
// reset clears the row position, row state and all stage valid bits
// ----------------------------------------------------------------------------
module detection_row_decoder import drd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] element_value,
	input  logic frame_start,
	output logic out_valid,
	input  logic out_stall,
	output logic [6:0] class_index,
	output logic [30:0] confidence,
	output logic signed [15:0] box_left,
	output logic signed [15:0] box_top,
	output logic signed [15:0] box_width,
	output logic signed [15:0] box_height,
	input  logic cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [7:0] class_count_q;
	logic [16:0] conf_limit_q, score_limit_q;
	logic [23:0] scale_x_q, scale_y_q;

	logic [7:0] row_position_q;
	logic signed [31:0] centre_x_q, centre_y_q, size_w_q, size_h_q;
	logic signed [31:0] objectness_q, best_score_q;
	logic [6:0] best_class_q;

	logic valid_s1;
	cand_t cand_s1;
	logic s1_free, s2_free;

	logic accept, row_end, pass, emit;
	logic [7:0] pos, classes, last;
	logic signed [31:0] best_next;
	logic [6:0] class_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= 8'd80;
			conf_limit_q <= 17'd45875;
			score_limit_q <= 17'd52429;
			scale_x_q <= 24'd65536;
			scale_y_q <= 24'd65536;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CLASS_COUNT: class_count_q <= cfg_data[7:0];
				CFG_CONF_LIMIT: conf_limit_q <= cfg_data[16:0];
				CFG_SCORE_LIMIT: score_limit_q <= cfg_data[16:0];
				CFG_SCALE_X: scale_x_q <= cfg_data;
				CFG_SCALE_Y: scale_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		classes = class_count_q;
		if (classes == 8'd0) begin
			classes = 8'd1;
		end
		if (classes > 8'(CLASS_CAP)) begin
			classes = 8'(CLASS_CAP);
		end
		last = classes + 8'd4;
	end

	assign accept = in_valid && !in_stall;
	assign pos = frame_start ? 8'd0 : row_position_q;
	assign row_end = pos >= last;

	always_comb begin
		best_next = best_score_q;
		class_next = best_class_q;
		if (pos == 8'd5) begin
			best_next = element_value;
			class_next = 7'd0;
		end else if (pos > 8'd5 && element_value > best_score_q) begin
			best_next = element_value;
			class_next = 7'(pos - 8'd5);
		end
	end

	assign pass = (objectness_q >= $signed({15'd0, conf_limit_q}))
		&& (best_next > $signed({15'd0, score_limit_q}));
	assign emit = accept && row_end && pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_position_q <= 8'd0;
			centre_x_q <= '0;
			centre_y_q <= '0;
			size_w_q <= '0;
			size_h_q <= '0;
			objectness_q <= '0;
			best_score_q <= '0;
			best_class_q <= '0;
		end else if (accept) begin
			row_position_q <= row_end ? 8'd0 : pos + 8'd1;
			case (pos)
				8'd0: centre_x_q <= element_value;
				8'd1: centre_y_q <= element_value;
				8'd2: size_w_q <= element_value;
				8'd3: size_h_q <= element_value;
				8'd4: objectness_q <= element_value;
				default: begin
					best_score_q <= best_next;
					best_class_q <= class_next;
				end
			endcase
		end
	end

	assign s1_free = !valid_s1 || s2_free;
	assign in_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && emit) begin
			cand_s1.cls <= class_next;
			cand_s1.conf <= objectness_q[30:0];
			cand_s1.lx <= 34'(centre_x_q) + 34'(centre_x_q) - 34'(size_w_q);
			cand_s1.ty <= 34'(centre_y_q) + 34'(centre_y_q) - 34'(size_h_q);
			cand_s1.w <= size_w_q;
			cand_s1.h <= size_h_q;
		end
	end

	drd_box_scale u_box_scale (
		.clk(clk),
		.arst_n(arst_n),
		.cand_valid(valid_s1),
		.cand(cand_s1),
		.cand_free(s2_free),
		.scale_x(scale_x_q),
		.scale_y(scale_y_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.class_index(class_index),
		.confidence(confidence),
		.box_left(box_left),
		.box_top(box_top),
		.box_width(box_width),
		.box_height(box_height)
	);

`ifndef NO_ASSERTIONS
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && !s2_free)
		else $error("input stalled with a free candidate stage");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_position_q <= 8'(CLASS_CAP + 4))
		else $error("row position past the longest row");

	a_end_on_score: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && row_end) |-> pos >= 8'd5)
		else $error("row ended before the class scores");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> valid_s1 && $stable(cand_s1))
		else $error("blocked candidate changed");
`endif

endmodule
